### rtl/core/bsa_pkg.sv
package bsa_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int NUM_REGS_DEF   = 16;
	localparam int FIELD_W        = 16;
	localparam int ADDR_W         = 4;

	// Operand pair, R listed first and S second.
	typedef enum logic [2:0] {
		SRC_AQ = 3'd0,
		SRC_AB = 3'd1,
		SRC_ZQ = 3'd2,
		SRC_ZB = 3'd3,
		SRC_ZA = 3'd4,
		SRC_DA = 3'd5,
		SRC_DQ = 3'd6,
		SRC_DZ = 3'd7
	} src_t;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUBR = 3'd1,
		OP_SUBS = 3'd2,
		OP_OR   = 3'd3,
		OP_AND  = 3'd4,
		OP_NOTRS = 3'd5,
		OP_XOR  = 3'd6,
		OP_XNOR = 3'd7
	} alu_op_t;

	typedef enum logic [2:0] {
		DST_QREG  = 3'd0,
		DST_NOP   = 3'd1,
		DST_RAMA  = 3'd2,
		DST_RAMF  = 3'd3,
		DST_RAMQD = 3'd4,
		DST_RAMD  = 3'd5,
		DST_RAMQU = 3'd6,
		DST_RAMU  = 3'd7
	} dest_t;

	typedef struct packed {
		logic carry;
		logic ovf;
	} alu_flags_t;

endpackage

### rtl/core/bsa_alu.sv
module bsa_alu import bsa_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic [DATA_WIDTH-1:0] r,
	input  logic [DATA_WIDTH-1:0] s,
	input  alu_op_t               op,
	input  logic                  cin,
	output logic [DATA_WIDTH-1:0] f,
	output alu_flags_t            flags
);

	logic [DATA_WIDTH-1:0] x;
	logic [DATA_WIDTH-1:0] yv;
	logic [DATA_WIDTH:0]   sum;
	logic [DATA_WIDTH-1:0] low;

	// Subtraction is done as an add of the complemented operand plus carry in.
	always_comb begin
		case (op)
			OP_SUBR: begin
				x  = s;
				yv = ~r;
			end
			OP_SUBS: begin
				x  = r;
				yv = ~s;
			end
			default: begin
				x  = r;
				yv = s;
			end
		endcase
	end

	assign sum = {1'b0, x} + {1'b0, yv} + {{DATA_WIDTH{1'b0}}, cin};
	assign low = {1'b0, x[DATA_WIDTH-2:0]} + {1'b0, yv[DATA_WIDTH-2:0]}
		+ {{(DATA_WIDTH-1){1'b0}}, cin};

	always_comb begin
		flags = '0;
		if (op inside {OP_ADD, OP_SUBR, OP_SUBS}) begin
			f           = sum[DATA_WIDTH-1:0];
			flags.carry = sum[DATA_WIDTH];
			flags.ovf   = sum[DATA_WIDTH] ^ low[DATA_WIDTH-1];
		end else begin
			case (op)
				OP_OR:    f = r | s;
				OP_AND:   f = r & s;
				OP_NOTRS: f = ~r & s;
				OP_XOR:   f = r ^ s;
				default:  f = ~(r ^ s);
			endcase
		end
	end

endmodule

### rtl/core/bit_slice_alu_register_file.sv
// Bit-slice ALU with a register file and a Q register. Each input transaction is one
// microinstruction: it picks an operand pair from register ports A and B, the Q register,
// the direct data input and zero, applies one of eight ALU functions and writes the result
// (plain or shifted) back to register B and/or Q, returning Y and the carry, overflow, zero
// and sign flags as one output transaction. The block takes one transaction per clock while
// the output side does not stall: the register file is a synchronous memory that is read at
// the accepting edge, the ALU and write back run from stage 1 once the output register
// can take the result, and the result lands in it. A write to the entry that the next
// microinstruction reads is forwarded, so back-to-back dependent microinstructions see the
// new value. Register file and Q clear to zero at reset, with no clearing pass; a register
// address at or beyond NUM_REGS reads as zero and is never written.
module bit_slice_alu_register_file import bsa_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int NUM_REGS   = NUM_REGS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         source_sel,
	input  logic [2:0]         mode,
	input  logic [2:0]         dest_sel,
	input  logic [ADDR_W-1:0]  a_addr,
	input  logic [ADDR_W-1:0]  b_addr,
	input  logic [FIELD_W-1:0] data_in,
	input  logic               carry_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] y_out,
	output logic               carry_out,
	output logic               overflow,
	output logic               zero_flag,
	output logic               sign_flag
);

	localparam int IDX_W = $clog2(NUM_REGS);
	localparam logic [ADDR_W:0] NREGS = (ADDR_W + 1)'(NUM_REGS);

	// Register file storage. Valid bits give the reset value for entries never written.
	logic [DATA_WIDTH-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0]   vld_q;

	// Stage 1: the microinstruction whose operands were just read.
	logic                  valid_s1;
	src_t                  src_s1;
	alu_op_t               op_s1;
	dest_t                 dst_s1;
	logic [ADDR_W-1:0]     a_addr_s1;
	logic [ADDR_W-1:0]     b_addr_s1;
	logic [DATA_WIDTH-1:0] d_s1;
	logic                  cin_s1;
	logic [DATA_WIDTH-1:0] rd_a_s1;
	logic [DATA_WIDTH-1:0] rd_b_s1;
	logic                  a_ok_s1;
	logic                  b_ok_s1;

	// Most recent register file write, used to forward over the read of the same edge.
	logic                  fwd_vld_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [DATA_WIDTH-1:0] fwd_data_q;

	logic [DATA_WIDTH-1:0] q_q;

	logic                  out_valid_q;
	logic [FIELD_W-1:0]    y_q;
	logic                  carry_q;
	logic                  ovf_q;
	logic                  zero_q;
	logic                  sign_q;

	logic                  in_accept;
	logic                  exec;
	logic [IDX_W-1:0]      a_idx;
	logic [IDX_W-1:0]      b_idx;
	logic                  a_in_range;
	logic                  b_in_range;

	logic [DATA_WIDTH-1:0] a_val;
	logic [DATA_WIDTH-1:0] b_val;
	logic [DATA_WIDTH-1:0] r_op;
	logic [DATA_WIDTH-1:0] s_op;
	logic [DATA_WIDTH-1:0] f;
	alu_flags_t            flags;
	logic                  f_sign;
	logic [DATA_WIDTH-1:0] y_val;
	logic [DATA_WIDTH-1:0] q_next;
	logic                  q_we;
	logic                  rf_we;
	logic                  wr_ok;
	logic [IDX_W-1:0]      wr_idx;

	// RAMA writes F while Y shows A; every other writing destination stores Y.
	function automatic logic [DATA_WIDTH-1:0] f_wr_data(dest_t dst,
		logic [DATA_WIDTH-1:0] fv, logic [DATA_WIDTH-1:0] yv);
		return (dst == DST_RAMA) ? fv : yv;
	endfunction

	// The stage advances when the output register is free or is being emptied,
	// so a new transaction enters every clock unless the output side stalls.
	assign exec      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !exec;
	assign in_accept = in_valid && !in_stall;

	assign a_idx      = a_addr[IDX_W-1:0];
	assign b_idx      = b_addr[IDX_W-1:0];
	assign a_in_range = {1'b0, a_addr} < NREGS;
	assign b_in_range = {1'b0, b_addr} < NREGS;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			mem[wr_idx] <= f_wr_data(dst_s1, f, y_val);
		end
		if (in_accept) begin
			rd_a_s1 <= mem[a_idx];
			rd_b_s1 <= mem[b_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			src_s1    <= src_t'(source_sel);
			op_s1     <= alu_op_t'(mode);
			dst_s1    <= dest_t'(dest_sel);
			a_addr_s1 <= a_addr;
			b_addr_s1 <= b_addr;
			d_s1      <= DATA_WIDTH'(data_in);
			cin_s1    <= carry_in;
			a_ok_s1   <= a_in_range && vld_q[a_idx];
			b_ok_s1   <= b_in_range && vld_q[b_idx];
		end
	end

	// Operand fetch with forwarding of the write made at the reading edge.
	always_comb begin
		if (fwd_vld_q && fwd_addr_q == a_addr_s1) begin
			a_val = fwd_data_q;
		end else if (a_ok_s1) begin
			a_val = rd_a_s1;
		end else begin
			a_val = '0;
		end
		if (fwd_vld_q && fwd_addr_q == b_addr_s1) begin
			b_val = fwd_data_q;
		end else if (b_ok_s1) begin
			b_val = rd_b_s1;
		end else begin
			b_val = '0;
		end
	end

	always_comb begin
		case (src_s1)
			SRC_AQ: begin
				r_op = a_val;
				s_op = q_q;
			end
			SRC_AB: begin
				r_op = a_val;
				s_op = b_val;
			end
			SRC_ZQ: begin
				r_op = '0;
				s_op = q_q;
			end
			SRC_ZB: begin
				r_op = '0;
				s_op = b_val;
			end
			SRC_ZA: begin
				r_op = '0;
				s_op = a_val;
			end
			SRC_DA: begin
				r_op = d_s1;
				s_op = a_val;
			end
			SRC_DQ: begin
				r_op = d_s1;
				s_op = q_q;
			end
			default: begin
				r_op = d_s1;
				s_op = '0;
			end
		endcase
	end

	bsa_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.r    (r_op),
		.s    (s_op),
		.op   (op_s1),
		.cin  (cin_s1),
		.f    (f),
		.flags(flags)
	);

	assign f_sign = f[DATA_WIDTH-1];

	// Destination decode: Y value, Q update and whether register B is written.
	// Down shifts fill register B from the sign of F and Q from bit 0 of F; up shifts
	// fill register B from the carry out and Q from the sign of F.
	always_comb begin
		y_val  = f;
		q_next = q_q;
		q_we   = 1'b0;
		rf_we  = 1'b0;
		case (dst_s1)
			DST_QREG: begin
				q_next = f;
				q_we   = 1'b1;
			end
			DST_NOP: begin
				y_val = f;
			end
			DST_RAMA: begin
				y_val = a_val;
				rf_we = 1'b1;
			end
			DST_RAMF: begin
				rf_we = 1'b1;
			end
			DST_RAMQD: begin
				y_val  = {f_sign, f[DATA_WIDTH-1:1]};
				q_next = {f[0], q_q[DATA_WIDTH-1:1]};
				q_we   = 1'b1;
				rf_we  = 1'b1;
			end
			DST_RAMD: begin
				y_val = {f_sign, f[DATA_WIDTH-1:1]};
				rf_we = 1'b1;
			end
			DST_RAMQU: begin
				y_val  = {f[DATA_WIDTH-2:0], flags.carry};
				q_next = {q_q[DATA_WIDTH-2:0], f_sign};
				q_we   = 1'b1;
				rf_we  = 1'b1;
			end
			default: begin
				y_val = {f[DATA_WIDTH-2:0], flags.carry};
				rf_we = 1'b1;
			end
		endcase
		rf_we = rf_we && exec && wr_ok;
		q_we  = q_we && exec;
	end

	assign wr_ok  = {1'b0, b_addr_s1} < NREGS;
	assign wr_idx = b_addr_s1[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
			q_q       <= '0;
		end else begin
			if (rf_we) begin
				vld_q[wr_idx] <= 1'b1;
				fwd_vld_q     <= 1'b1;
			end
			if (q_we) begin
				q_q <= q_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			fwd_addr_q <= b_addr_s1;
			fwd_data_q <= f_wr_data(dst_s1, f, y_val);
		end
	end

	// Output register: holds a finished transaction until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			y_q     <= FIELD_W'(y_val);
			carry_q <= flags.carry;
			ovf_q   <= flags.ovf;
			zero_q  <= (f == '0);
			sign_q  <= f_sign;
		end
	end

	assign out_valid = out_valid_q;
	assign y_out     = y_q;
	assign carry_out = carry_q;
	assign overflow  = ovf_q;
	assign zero_flag = zero_q;
	assign sign_flag = sign_q;

endmodule

### verif/tb_bit_slice_alu_register_file.sv
`timescale 1ns / 1ps

module tb_bit_slice_alu_register_file;
	import bsa_pkg::*;

	localparam int W            = DATA_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int GAP_PERCENT  = 23;
	// The block answers from its output register after the stage registers; the drain at the
	// end catches any output transaction that should not be there.
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 60000;

	// One microinstruction as the sender offers it.
	typedef struct {
		src_t          src;
		alu_op_t       op;
		dest_t         dst;
		logic [3:0]    a;
		logic [3:0]    b;
		logic [W-1:0]  d;
		logic          cin;
	} uinstr_t;

	// Everything that one output transaction carries.
	typedef struct {
		logic [W-1:0] y;
		logic         c;
		logic         v;
		logic         z;
		logic         s;
	} alu_result_t;

	// A directed row: either the result is typed in by hand, or the shadow
	// datapath supplies it.
	typedef struct {
		uinstr_t     ui;
		bit          typed;
		alu_result_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         source_sel = '0;
	logic [2:0]         mode = '0;
	logic [2:0]         dest_sel = '0;
	logic [ADDR_W-1:0]  a_addr = '0;
	logic [ADDR_W-1:0]  b_addr = '0;
	logic [FIELD_W-1:0] data_in = '0;
	logic               carry_in = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [FIELD_W-1:0] y_out;
	logic               carry_out;
	logic               overflow;
	logic               zero_flag;
	logic               sign_flag;

	// Shadow copy of the architectural state, advanced once per accepted
	// microinstruction.
	logic [W-1:0] shadow_regs [16];
	logic [W-1:0] shadow_q;

	alu_result_t pending_results[$];
	dir_row_t    dir_rows[$];

	int  error_count   = 0;
	int  results_seen  = 0;
	int  issued_count  = 0;
	int  cycle_count   = 0;
	int  hold_left     = 0;
	bit  hold_done     = 1'b0;
	bit  gaps_on       = 1'b1;

	bit_slice_alu_register_file dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.source_sel (source_sel),
		.mode       (mode),
		.dest_sel   (dest_sel),
		.a_addr     (a_addr),
		.b_addr     (b_addr),
		.data_in    (data_in),
		.carry_in   (carry_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.y_out      (y_out),
		.carry_out  (carry_out),
		.overflow   (overflow),
		.zero_flag  (zero_flag),
		.sign_flag  (sign_flag)
	);

	always #2 clk = ~clk;

	// Executes one microinstruction on the shadow state and returns what the
	// block has to answer. The adder works one bit wider than the datapath so
	// that the carry out falls out of the top bit; the carry into the sign bit
	// comes from a separate sum of the low bits, and overflow is the XOR of
	// the two. Logic functions leave both carry and overflow at zero.
	function automatic alu_result_t execute_microinstr(uinstr_t ui);
		logic [W-1:0] a_val;
		logic [W-1:0] b_val;
		logic [W-1:0] r;
		logic [W-1:0] s;
		logic [W-1:0] x;
		logic [W-1:0] yv;
		logic [W-1:0] f;
		logic [W-1:0] y;
		logic [W:0]   sum;
		logic [W-1:0] low;
		logic         co;
		logic         ov;
		alu_result_t  res;
		a_val = shadow_regs[ui.a];
		b_val = shadow_regs[ui.b];
		co = 1'b0;
		ov = 1'b0;
		x = '0;
		yv = '0;
		case (ui.src)
			SRC_AQ: begin r = a_val; s = shadow_q; end
			SRC_AB: begin r = a_val; s = b_val; end
			SRC_ZQ: begin r = '0; s = shadow_q; end
			SRC_ZB: begin r = '0; s = b_val; end
			SRC_ZA: begin r = '0; s = a_val; end
			SRC_DA: begin r = ui.d; s = a_val; end
			SRC_DQ: begin r = ui.d; s = shadow_q; end
			default: begin r = ui.d; s = '0; end
		endcase
		case (ui.op)
			OP_ADD, OP_SUBR, OP_SUBS: begin
				if (ui.op == OP_ADD) begin
					x = r;
					yv = s;
				end else if (ui.op == OP_SUBR) begin
					x = s;
					yv = ~r;
				end else begin
					x = r;
					yv = ~s;
				end
				sum = {1'b0, x} + {1'b0, yv} + {{W{1'b0}}, ui.cin};
				f = sum[W-1:0];
				co = sum[W];
				low = {1'b0, x[W-2:0]} + {1'b0, yv[W-2:0]} + {{(W-1){1'b0}}, ui.cin};
				ov = co ^ low[W-1];
			end
			OP_OR:    f = r | s;
			OP_AND:   f = r & s;
			OP_NOTRS: f = ~r & s;
			OP_XOR:   f = r ^ s;
			default:  f = ~(r ^ s);
		endcase
		y = f;
		case (ui.dst)
			DST_QREG: shadow_q = f;
			DST_NOP: ;
			DST_RAMA: begin
				shadow_regs[ui.b] = f;
				y = a_val;
			end
			DST_RAMF: shadow_regs[ui.b] = f;
			DST_RAMQD, DST_RAMD: begin
				// Arithmetic shift down; Q takes bit 0 of F in its top bit.
				y = {f[W-1], f[W-1:1]};
				shadow_regs[ui.b] = y;
				if (ui.dst == DST_RAMQD) begin
					shadow_q = {f[0], shadow_q[W-1:1]};
				end
			end
			default: begin
				// Shift up with the carry out entering bit 0; Q takes the sign of F.
				y = {f[W-2:0], co};
				shadow_regs[ui.b] = y;
				if (ui.dst == DST_RAMQU) begin
					shadow_q = {shadow_q[W-2:0], f[W-1]};
				end
			end
		endcase
		res.y = y;
		res.c = co;
		res.v = ov;
		res.z = (f == '0);
		res.s = f[W-1];
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input logic [W-1:0] got,
			input logic [W-1:0] want);
		$display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic void put_row(input src_t src, input alu_op_t op, input dest_t dst,
			input logic [3:0] a, input logic [3:0] b, input logic [W-1:0] d,
			input logic cin, input bit typed, input logic [W-1:0] y,
			input logic c, input logic v, input logic z, input logic s);
		dir_row_t row;
		row.ui = '{src, op, dst, a, b, d, cin};
		row.typed = typed;
		row.res = '{y, c, v, z, s};
		dir_rows.push_back(row);
	endfunction

	// Random microinstructions. Data favors the corners of the range half of
	// the time, since those are where carries and overflows turn over.
	function automatic uinstr_t random_microinstr();
		uinstr_t ui;
		ui.src = src_t'($urandom_range(0, 7));
		ui.op = alu_op_t'($urandom_range(0, 7));
		ui.dst = dest_t'($urandom_range(0, 7));
		ui.a = 4'($urandom_range(0, 15));
		ui.b = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 7))
			0: ui.d = '0;
			1: ui.d = '1;
			2: ui.d = {1'b1, {(W-1){1'b0}}};
			3: ui.d = {1'b0, {(W-1){1'b1}}};
			default: ui.d = W'($urandom);
		endcase
		ui.cin = 1'($urandom_range(0, 1));
		return ui;
	endfunction

	// Offers one transaction and holds it until the block takes it. The fields
	// are only touched once the previous transaction has gone, so a stalled
	// payload never changes. The shadow state advances at the accepting edge.
	task automatic issue(input uinstr_t ui, input bit typed, input alu_result_t typed_res);
		alu_result_t predicted;
		while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		source_sel <= ui.src;
		mode <= ui.op;
		dest_sel <= ui.dst;
		a_addr <= ui.a;
		b_addr <= ui.b;
		data_in <= ui.d;
		carry_in <= ui.cin;
		do begin
			@(posedge clk);
		end while (in_stall);
		predicted = execute_microinstr(ui);
		pending_results.push_back(typed ? typed_res : predicted);
		issued_count++;
	endtask

	// Receiver side. Values are read right after the edge, before any of this
	// edge's updates land, so they are the ones the edge itself saw. Once a
	// hundred results have come, the receiver stalls for a long stretch so the
	// pipeline backs up and the block has to stall its input.
	always @(posedge clk) begin
		alu_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unexpected result, y_out", y_out, '0);
				end else begin
					want = pending_results.pop_front();
					if (y_out !== want.y) flag_mismatch("y_out", y_out, want.y);
					if (carry_out !== want.c) begin
						flag_mismatch("carry_out", W'(carry_out), W'(want.c));
					end
					if (overflow !== want.v) begin
						flag_mismatch("overflow", W'(overflow), W'(want.v));
					end
					if (zero_flag !== want.z) begin
						flag_mismatch("zero_flag", W'(zero_flag), W'(want.z));
					end
					if (sign_flag !== want.s) begin
						flag_mismatch("sign_flag", W'(sign_flag), W'(want.s));
					end
				end
				results_seen++;
			end
			if (!hold_done && results_seen >= 100) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
			end
		end
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, pending_results.size());
			$display("tb_bit_slice_alu_register_file: done, errors");
			$finish;
		end
	end

	initial begin
		dir_row_t    row;
		uinstr_t     ui;
		alu_result_t none;
		none = '{'0, 1'b0, 1'b0, 1'b0, 1'b0};
		foreach (shadow_regs[i]) shadow_regs[i] = '0;
		shadow_q = '0;

		// Directed table. The first rows run on the reset state and the corners
		// of the adder, where the answer is plain; the rest walk every operand
		// pair, function and destination through both ends of the register
		// file, with back-to-back rows reusing the register just written.
		// Zero plus Q right after reset: everything clear except the zero flag.
		put_row(SRC_ZQ, OP_ADD,   DST_NOP,   0,  0, 16'h0000, 0, 1, 16'h0000, 0, 0, 1, 0);
		// Largest positive value plus one wraps to the most negative value.
		put_row(SRC_DZ, OP_ADD,   DST_NOP,   0,  0, 16'h7FFF, 1, 1, 16'h8000, 0, 1, 0, 1);
		// All ones plus one: carry out, no signed overflow, zero result.
		put_row(SRC_DZ, OP_ADD,   DST_NOP,   0,  0, 16'hFFFF, 1, 1, 16'h0000, 1, 0, 1, 0);
		// Logic functions ignore the carry input and report no carry.
		put_row(SRC_DZ, OP_XNOR,  DST_NOP,   0,  0, 16'h0000, 1, 1, 16'hFFFF, 0, 0, 0, 1);
		put_row(SRC_DZ, OP_ADD,   DST_RAMF,  0, 15, 16'hFFFF, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DZ, OP_OR,    DST_QREG,  0,  0, 16'h8000, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_AQ, OP_ADD,   DST_RAMA, 15,  1, 16'h0000, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_AB, OP_SUBR,  DST_RAMQD, 15, 1, 16'h0000, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_ZB, OP_SUBS,  DST_RAMD,  0, 15, 16'h0000, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_ZA, OP_AND,   DST_RAMQU, 15, 2, 16'h0000, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DA, OP_NOTRS, DST_RAMU, 15,  3, 16'hAAAA, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DQ, OP_XOR,   DST_QREG,  0,  0, 16'h5555, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_AB, OP_ADD,   DST_RAMU,  1,  1, 16'h0000, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_AB, OP_OR,    DST_RAMF,  1,  1, 16'h0000, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DA, OP_SUBR,  DST_RAMQU, 0,  0, 16'h0001, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DQ, OP_SUBS,  DST_RAMQD, 3,  3, 16'hFFFF, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_AQ, OP_XNOR,  DST_RAMA,  2,  2, 16'h1234, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_ZQ, OP_NOTRS, DST_NOP,  14, 14, 16'h0000, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DZ, OP_AND,   DST_RAMF,  0,  0, 16'hFFFF, 0, 0, '0, 0, 0, 0, 0);
		put_row(SRC_AB, OP_XOR,   DST_RAMD, 15,  0, 16'h0000, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_DA, OP_SUBS,  DST_RAMQU, 0, 15, 16'h8000, 1, 0, '0, 0, 0, 0, 0);
		put_row(SRC_ZB, OP_ADD,   DST_RAMQD, 0, 15, 16'h0000, 0, 0, '0, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (dir_rows.size() != 0) begin
			row = dir_rows.pop_front();
			issue(row.ui, row.typed, row.res);
		end

		// Random microinstructions. The middle third runs with no idling on
		// either side, so the block sees a full-rate stream.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_on = !(n >= 150 && n < 300);
			ui = random_microinstr();
			issue(ui, 1'b0, none);
		end
		gaps_on = 1'b1;
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d microinstructions over all operand pairs, ALU functions and",
			issued_count);
		$display("destinations, with random stalls on both sides and one long output hold.");
		if (error_count == 0) begin
			$display("tb_bit_slice_alu_register_file: done, clean");
		end else begin
			$display("tb_bit_slice_alu_register_file: done, errors");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_alu.sv
rtl/core/bit_slice_alu_register_file.sv
verif/tb_bit_slice_alu_register_file.sv
